>>> design/pic3_pkg.sv
// ----------------------------------------------------------------------------
// pic3_pkg: shared types and constants for the convex polygon point test
// Widths of the vertex store, the multiply-accumulate datapath and the
// control records that travel between the top level and the core.
// ----------------------------------------------------------------------------
package pic3_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int VTX_W  = 3 * COORD_WIDTH;

  // Exact integer widths of the geometry.
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int CROSS_W = 2 * COORD_WIDTH + 3;
  localparam int LO_W    = DIFF_W;
  localparam int PART_W  = CROSS_W - LO_W;
  localparam int PROD_W  = CROSS_W + PART_W;
  localparam int ACC_W   = 4 * COORD_WIDTH + 8;

  // Each cross product or dot product takes six multiplier issues.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(5);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic signed [PART_W-1:0]      part_t;

  typedef enum logic [1:0] {
    ST_INSIDE     = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_DEGENERATE = 2'd2
  } status_t;

  // Where a finished accumulation is written.
  typedef enum logic [2:0] {
    DST_N0,
    DST_N1,
    DST_N2,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_DOT
  } dest_t;

  typedef struct packed {
    logic   valid;
    cross_t a;
    part_t  b;
    logic   shift;
    logic   sub;
    logic   first;
    logic   last;
    dest_t  dest;
  } mac_op_t;

  typedef struct packed {
    logic                    valid;
    dest_t                   dest;
    logic signed [ACC_W-1:0] acc;
  } mac_res_t;

  typedef struct packed {
    logic              write;
    logic              query;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] last_idx;
    coord_t            x;
    coord_t            y;
    coord_t            z;
  } core_req_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    status_t status;
  } core_stat_t;

endpackage

>>> design/pic3_ram.sv
// ----------------------------------------------------------------------------
// pic3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module pic3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pic3_mac.sv
// ----------------------------------------------------------------------------
// pic3_mac: shared signed multiply-accumulate unit
// A registered multiplier feeds a wide accumulator; each operation can
// subtract, shift the product up by one partial-product slice, start a
// fresh sum and mark the sum as finished for a destination register.
// ----------------------------------------------------------------------------
module pic3_mac
  import pic3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mac_op_t  op,
  output mac_res_t res,
  output logic     busy
);

  logic signed [PROD_W-1:0] prod;
  logic                     valid1;
  logic                     shift1;
  logic                     sub1;
  logic                     first1;
  logic                     last1;
  dest_t                    dest1;

  logic                     done;
  dest_t                    dest;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= op.valid;
      done   <= valid1 && last1;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= op.a * op.b;
    shift1 <= op.shift;
    sub1   <= op.sub;
    first1 <= op.first;
    last1  <= op.last;
    dest1  <= op.dest;
    dest   <= dest1;
    if (valid1) begin
      acc <= sub1 ? (base - term) : (base + term);
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign term     = shift1 ? (prod_ext <<< LO_W) : prod_ext;
  assign base     = first1 ? '0 : acc;

  assign res.valid = done;
  assign res.dest  = dest;
  assign res.acc   = acc;
  assign busy      = valid1 || done;

endmodule

>>> design/pic3_core.sv
// ----------------------------------------------------------------------------
// pic3_core: vertex store and query sequencer
// Holds the vertex RAM and steps the shared multiply-accumulate unit through
// the polygon normal and, edge by edge, the signed side test of the point.
// ----------------------------------------------------------------------------
module pic3_core
  import pic3_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_req_t  req,
  input  logic       res_ready,
  output core_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD1,
    S_LOAD2,
    S_LOAD3,
    S_NORMAL,
    S_NWAIT,
    S_EREAD,
    S_ELOAD,
    S_ECROSS,
    S_CWAIT,
    S_EDOT,
    S_DWAIT,
    S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [ADDR_W-1:0] edge_idx;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] next_idx;
  logic [ADDR_W-1:0] raddr;
  logic [VTX_W-1:0]  rdata;

  coord_t  p   [3];
  coord_t  va  [3];
  coord_t  vb  [3];
  coord_t  rv  [3];
  diff_t   e1  [3];
  diff_t   e2  [3];
  cross_t  nrm [3];
  cross_t  t   [3];
  logic    dot_neg;
  status_t result;

  logic [1:0] k;
  logic [1:0] i1;
  logic [1:0] i2;

  mac_op_t  op;
  mac_res_t res;
  logic     mac_busy;
  logic     nrm_zero;

  pic3_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (req.write),
    .waddr (req.slot),
    .wdata ({req.x, req.y, req.z}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pic3_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .res  (res),
    .busy (mac_busy)
  );

  assign rv[0] = coord_t'(rdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);
  assign rv[1] = coord_t'(rdata[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign rv[2] = coord_t'(rdata[COORD_WIDTH-1:0]);

  assign next_idx = (edge_idx == last_idx) ? '0 : edge_idx + 1'b1;
  assign nrm_zero = (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);

  always_comb begin
    case (state)
      S_LOAD1: raddr = ADDR_W'(1);
      S_LOAD2: raddr = ADDR_W'(2);
      S_EREAD: raddr = next_idx;
      default: raddr = '0;
    endcase
  end

  // Component k of a x b is a[i1]*b[i2] - a[i2]*b[i1].
  assign k = step[2:1];

  always_comb begin
    case (k)
      2'd0: begin
        i1 = 2'd1;
        i2 = 2'd2;
      end
      2'd1: begin
        i1 = 2'd2;
        i2 = 2'd0;
      end
      default: begin
        i1 = 2'd0;
        i2 = 2'd1;
      end
    endcase
  end

  always_comb begin
    op = '0;
    case (state)
      S_NORMAL, S_ECROSS: begin
        op.valid = 1'b1;
        op.a     = cross_t'(step[0] ? e1[i2] : e1[i1]);
        op.b     = part_t'(step[0] ? e2[i1] : e2[i2]);
        op.sub   = step[0];
        op.first = !step[0];
        op.last  = step[0];
        case (k)
          2'd0:    op.dest = (state == S_NORMAL) ? DST_N0 : DST_T0;
          2'd1:    op.dest = (state == S_NORMAL) ? DST_N1 : DST_T1;
          default: op.dest = (state == S_NORMAL) ? DST_N2 : DST_T2;
        endcase
      end
      S_EDOT: begin
        // The low slice of t is unsigned, the high slice carries the sign.
        op.valid = 1'b1;
        op.a     = nrm[k];
        op.b     = step[0] ? $signed(t[k][CROSS_W-1:LO_W])
                           : $signed({1'b0, t[k][LO_W-1:0]});
        op.shift = step[0];
        op.first = (step == '0);
        op.last  = (step == LAST_STEP);
        op.dest  = DST_DOT;
      end
      default: op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      if (res.valid) begin
        case (res.dest)
          DST_N0:  nrm[0] <= cross_t'(res.acc[CROSS_W-1:0]);
          DST_N1:  nrm[1] <= cross_t'(res.acc[CROSS_W-1:0]);
          DST_N2:  nrm[2] <= cross_t'(res.acc[CROSS_W-1:0]);
          DST_T0:  t[0]   <= cross_t'(res.acc[CROSS_W-1:0]);
          DST_T1:  t[1]   <= cross_t'(res.acc[CROSS_W-1:0]);
          DST_T2:  t[2]   <= cross_t'(res.acc[CROSS_W-1:0]);
          default: dot_neg <= res.acc[ACC_W-1];
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.query) begin
            p[0]     <= req.x;
            p[1]     <= req.y;
            p[2]     <= req.z;
            last_idx <= req.last_idx;
            state    <= S_LOAD1;
          end
        end
        S_LOAD1: begin
          va    <= rv;
          state <= S_LOAD2;
        end
        S_LOAD2: begin
          vb    <= rv;
          state <= S_LOAD3;
        end
        S_LOAD3: begin
          for (int c = 0; c < 3; c++) begin
            e1[c] <= diff_t'(vb[c]) - diff_t'(va[c]);
            e2[c] <= diff_t'(rv[c]) - diff_t'(va[c]);
          end
          step  <= '0;
          state <= S_NORMAL;
        end
        S_NORMAL: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (!mac_busy) begin
            edge_idx <= '0;
            if (nrm_zero) begin
              result <= ST_DEGENERATE;
              state  <= S_DONE;
            end else begin
              state <= S_EREAD;
            end
          end
        end
        S_EREAD: begin
          state <= S_ELOAD;
        end
        S_ELOAD: begin
          vb <= rv;
          for (int c = 0; c < 3; c++) begin
            e1[c] <= diff_t'(rv[c]) - diff_t'(va[c]);
            e2[c] <= diff_t'(p[c]) - diff_t'(va[c]);
          end
          step  <= '0;
          state <= S_ECROSS;
        end
        S_ECROSS: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (!mac_busy) begin
            step  <= '0;
            state <= S_EDOT;
          end
        end
        S_EDOT: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (!mac_busy) begin
            if (dot_neg) begin
              result <= ST_OUTSIDE;
              state  <= S_DONE;
            end else if (edge_idx == last_idx) begin
              result <= ST_INSIDE;
              state  <= S_DONE;
            end else begin
              edge_idx <= edge_idx + 1'b1;
              va       <= vb;
              state    <= S_EREAD;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle   = (state == S_IDLE);
  assign stat.done   = (state == S_DONE);
  assign stat.status = result;

endmodule

>>> design/point_in_convex_polygon_3d_top.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_3d_top: point-in-convex-polygon test in 3D
// A vertex write is taken only while the core is idle. A query is answered
// by the single shared multiply-accumulate unit, which walks the polygon
// normal and then every edge in turn; a degenerate polygon answers after the
// normal alone. One query is in flight at a time; the core takes the next
// request once the answer has moved into the output register. Reset clears
// the control state and sets the vertex count to three; the vertex store is
// not cleared.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_3d_top
  import pic3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_write,
  input  logic [CNT_W-1:0]       cfg_data,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [SLOT_W-1:0]      vertex_slot,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status
);

  // The vertex table is a small RAM inside the core. A request with the write
  // mode stores one vertex and produces no result. A query request latches
  // the point, then the core forms the polygon normal from the first three
  // vertices and tests the point against every edge in turn, stopping at the
  // first edge the point lies outside of.

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_clamp;
  logic             accept;
  logic             slot_ok;
  logic             res_ready;
  status_t          result_status;
  core_req_t        req;
  core_stat_t       cstat;

  // The core takes a new request only while it is idle. A finished answer
  // sits in the output register, so the next request can already be taken
  // while that answer waits for the consumer.
  assign in_stall = !cstat.idle;
  assign accept   = in_valid && !in_stall;

  // Writes to slots beyond the table are dropped.
  assign slot_ok = (32'(vertex_slot) < MAX_VERTICES);

  // Counts below three act as three; counts above the table act as its size.
  always_comb begin
    if (vertex_count < CNT_W'(MIN_VERTICES)) begin
      n_clamp = CNT_W'(MIN_VERTICES);
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      n_clamp = CNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = vertex_count;
    end
  end

  assign req.write    = accept && (mode == MODE_WRITE) && slot_ok;
  assign req.query    = accept && (mode == MODE_QUERY);
  assign req.slot     = ADDR_W'(vertex_slot);
  assign req.last_idx = ADDR_W'(n_clamp - CNT_W'(1));
  assign req.x        = coord_x;
  assign req.y        = coord_y;
  assign req.z        = coord_z;

  // The output register is free when it is empty or being emptied this cycle.
  assign res_ready = !out_valid || !out_stall;

  pic3_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_ready (res_ready),
    .stat      (cstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(MIN_VERTICES);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (cstat.done && res_ready) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Answer payload; held while the consumer stalls.
  always_ff @(posedge clk) begin
    if (cstat.done && res_ready) begin
      result_status <= cstat.status;
    end
  end

  assign status = result_status;

endmodule
